// ----- design/coq_pkg.sv -----
// ----------------------------------------------------------------------------
// coq_pkg: shared types and codes for the credit ordered ready queue
// Field widths, action and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package coq_pkg;

  // fixed field widths of the channels
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned ID_FIELD_W  = 8;
  localparam int unsigned CRED_W      = 7;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned POS_FIELD_W = 4;
  localparam int unsigned TOTAL_W     = 5;

  // largest credit the credit field can carry
  localparam int unsigned CRED_FIELD_MAX = (1 << CRED_W) - 1;

  // action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CHANGE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  // broadcast control to every cell of the chain
  typedef struct packed {
    logic extract;  // close the gap at the first id match
    logic place;    // open a gap behind the last entry with credit >= key
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/coq_cell.sv -----
// ----------------------------------------------------------------------------
// coq_cell: one slot of the sorted queue chain
// Holds one entry, compares it with the broadcast key and takes data from
// its left or right neighbor when the chain opens or closes a gap.
// ----------------------------------------------------------------------------
`default_nettype none

module coq_cell #(
  parameter int unsigned ID_W = 8
) (
  input  wire logic                                   clk,
  input  wire coq_pkg::cell_ctl_t                     ctl,
  input  wire logic                                   occ,
  input  wire logic [ID_W-1:0]                        key_id,
  input  wire logic [coq_pkg::CRED_W-1:0]             key_cr,
  input  wire logic [ID_W+2*coq_pkg::CRED_W-1:0]      new_entry,
  input  wire logic [ID_W+2*coq_pkg::CRED_W-1:0]      left_entry,
  input  wire logic [ID_W+2*coq_pkg::CRED_W-1:0]      right_entry,
  input  wire logic                                   prior_in,
  input  wire logic                                   ge_left,
  output logic [ID_W+2*coq_pkg::CRED_W-1:0]           entry,
  output logic                                        hit,
  output logic                                        prior_out,
  output logic                                        ge,
  output logic                                        load
);
  import coq_pkg::*;

  localparam int unsigned EW = ID_W + 2 * CRED_W;

  logic [EW-1:0]     entry_r;
  logic [EW-1:0]     entry_nxt;
  logic              match;

  // entry layout: {id, create credit, current credit}
  assign match     = occ && (entry_r[EW-1 -: ID_W] == key_id);
  assign hit       = match && !prior_in;
  assign prior_out = prior_in || match;
  assign ge        = occ && (entry_r[CRED_W-1:0] >= key_cr);
  assign load      = ctl.place && !ge && ge_left;
  assign entry     = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.extract && prior_out) begin
      entry_nxt = right_entry;
    end else if (ctl.place && !ge) begin
      entry_nxt = ge_left ? new_entry : left_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ----- design/credit_ordered_ready_queue_unit.sv -----
// ----------------------------------------------------------------------------
// credit_ordered_ready_queue_unit: sorted thread ready queue
// Keeps thread entries ordered by descending current credit in a chain of
// cells; insert, remove, re-credit and look up, one result per action.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_action, in_thread_id, in_credit with in_valid / in_stall;
//   a transfer happens when in_valid is high and in_stall is low
//   result channel: one result per input transfer, out_valid / out_stall,
//   results come out in input order
//   each item passes the find state, which matches the id across all cells
//   and closes the gap of a removed entry, then the place state, which opens
//   a gap at the sorted place, loads the entry and registers the result;
//   in_stall is high in the place state, so a new item is taken only after
//   the previous one has left it
//   a new item is taken while a finished result still waits in the output
//   register; a stalled result holds the place state until the output frees
//   reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; the slot contents need no clearing since only slots below the
//   entry count are ever looked at
// ----------------------------------------------------------------------------
`default_nettype none

module credit_ordered_ready_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8,
  parameter int unsigned MAX_CREDIT  = 100
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [coq_pkg::ACT_W-1:0]            in_action,
  input  wire logic [coq_pkg::ID_FIELD_W-1:0]       in_thread_id,
  input  wire logic [coq_pkg::CRED_W-1:0]           in_credit,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [coq_pkg::STATUS_W-1:0]              out_status,
  output logic [coq_pkg::ID_FIELD_W-1:0]            out_found_id,
  output logic [coq_pkg::CRED_W-1:0]                out_found_create_credit,
  output logic [coq_pkg::CRED_W-1:0]                out_found_real_credit,
  output logic [coq_pkg::POS_FIELD_W-1:0]           out_found_position,
  output logic [coq_pkg::TOTAL_W-1:0]               out_entry_total,
  output logic                                      out_head_valid,
  output logic [coq_pkg::ID_FIELD_W-1:0]            out_head_id,
  output logic [coq_pkg::CRED_W-1:0]                out_head_credit
);
  import coq_pkg::*;

  // stored id keeps only the low ID_BITS bits of the id field
  localparam int unsigned ID_W  = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
  localparam int unsigned EW    = ID_W + 2 * CRED_W;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned POS_W = $clog2(QUEUE_DEPTH);
  // saturation limit seen through the credit field
  localparam int unsigned CAP   = (MAX_CREDIT < CRED_FIELD_MAX) ? MAX_CREDIT
                                                                : CRED_FIELD_MAX;
  localparam logic [CRED_W-1:0] CRED_CAP = CRED_W'(CAP);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic {
    S_FIND,   // idle / accepting; match and extract
    S_PLACE   // sorted insert and result write
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  // captured item
  logic [ACT_W-1:0]   act_r;
  logic [ID_W-1:0]    id_r;
  logic [CRED_W-1:0]  cr_r;
  logic               full_r;
  logic               found_r;
  logic [EW-1:0]      hit_ent_r;
  logic [POS_W-1:0]   hit_pos_r;

  // output register
  logic               out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [ID_FIELD_W-1:0]  out_found_id_r;
  logic [CRED_W-1:0]      out_found_cc_r;
  logic [CRED_W-1:0]      out_found_rc_r;
  logic [POS_FIELD_W-1:0] out_found_pos_r;
  logic [TOTAL_W-1:0]     out_total_r;
  logic                   out_head_valid_r;
  logic [ID_FIELD_W-1:0]  out_head_id_r;
  logic [CRED_W-1:0]      out_head_cr_r;

  // chain wiring
  cell_ctl_t          ctl;
  logic [EW-1:0]      ent [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] occ_vec;
  logic [QUEUE_DEPTH-1:0] hit_vec;
  logic [QUEUE_DEPTH-1:0] prior_vec;
  logic [QUEUE_DEPTH-1:0] ge_vec;
  logic [QUEUE_DEPTH-1:0] load_vec;

  logic               accept;
  logic               found;
  logic               out_free;
  logic               do_place;
  logic               finish;
  logic [ID_W-1:0]    key_id;
  logic [CRED_W-1:0]  in_cr_sat;
  logic [EW-1:0]      new_entry;
  logic [EW-1:0]      hit_ent;
  logic [POS_W-1:0]   hit_pos;
  logic [POS_W-1:0]   place_pos;
  logic [EW-1:0]      head_ent;

  // result fields before the output register
  logic [STATUS_W-1:0] res_status;
  logic [ID_W-1:0]     res_id;
  logic [CRED_W-1:0]   res_cc;
  logic [CRED_W-1:0]   res_rc;
  logic [POS_W-1:0]    res_pos;

  // handshakes
  assign in_stall = (state_r == S_PLACE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign finish   = (state_r == S_PLACE) && out_free;

  // id match key comes straight from the port, the credit key from the capture
  assign key_id    = in_thread_id[ID_W-1:0];
  assign in_cr_sat = (in_credit > CRED_CAP) ? CRED_CAP : in_credit;
  assign found     = prior_vec[QUEUE_DEPTH-1];

  // insert (queue not full) and re-credit (id found) place a new entry in the place state
  assign do_place = ((act_r == ACT_INSERT) && !full_r) ||
                    ((act_r == ACT_CHANGE) && found_r);

  assign ctl.extract = accept && ((in_action == ACT_REMOVE) || (in_action == ACT_CHANGE));
  assign ctl.place   = finish && do_place;

  // re-credit keeps the creation credit of the extracted entry
  assign new_entry = {id_r,
                      (act_r == ACT_INSERT) ? cr_r : hit_ent_r[2*CRED_W-1:CRED_W],
                      cr_r};

  // the cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [EW-1:0] left_ent;
    logic [EW-1:0] right_ent;
    logic          prior_in;
    logic          ge_left;

    assign occ_vec[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign prior_in = 1'b0;
      assign ge_left  = 1'b1;
    end else begin : g_mid
      assign left_ent = ent[i-1];
      assign prior_in = prior_vec[i-1];
      assign ge_left  = ge_vec[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    coq_cell #(
      .ID_W (ID_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ_vec[i]),
      .key_id      (key_id),
      .key_cr      (cr_r),
      .new_entry   (new_entry),
      .left_entry  (left_ent),
      .right_entry (right_ent),
      .prior_in    (prior_in),
      .ge_left     (ge_left),
      .entry       (ent[i]),
      .hit         (hit_vec[i]),
      .prior_out   (prior_vec[i]),
      .ge          (ge_vec[i]),
      .load        (load_vec[i])
    );
  end

  // one-hot to index and entry for the id hit and the load slot
  always_comb begin
    hit_pos   = '0;
    hit_ent   = '0;
    place_pos = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (hit_vec[i]) begin
        hit_pos = hit_pos | POS_W'(i);
        hit_ent = hit_ent | ent[i];
      end
      if (load_vec[i]) begin
        place_pos = place_pos | POS_W'(i);
      end
    end
  end

  // entry count after this cycle
  always_comb begin
    count_nxt = count_r;
    if (ctl.extract && found) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (ctl.place) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // head after the placement
  assign head_ent = (ctl.place && load_vec[0]) ? new_entry : ent[0];

  // result fields
  always_comb begin
    res_status = ST_OK;
    res_id     = '0;
    res_cc     = '0;
    res_rc     = '0;
    res_pos    = '0;
    case (act_r)
      ACT_INSERT: begin
        if (full_r) begin
          res_status = ST_FULL;
        end else begin
          res_id  = id_r;
          res_cc  = cr_r;
          res_rc  = cr_r;
          res_pos = place_pos;
        end
      end
      ACT_CHANGE: begin
        if (!found_r) begin
          res_status = ST_NOTFOUND;
        end else begin
          res_id  = id_r;
          res_cc  = hit_ent_r[2*CRED_W-1:CRED_W];
          res_rc  = cr_r;
          res_pos = place_pos;
        end
      end
      default: begin
        // remove and look up report the entry as it was found
        if (!found_r) begin
          res_status = ST_NOTFOUND;
        end else begin
          res_id  = hit_ent_r[EW-1 -: ID_W];
          res_cc  = hit_ent_r[2*CRED_W-1:CRED_W];
          res_rc  = hit_ent_r[CRED_W-1:0];
          res_pos = hit_pos_r;
        end
      end
    endcase
  end

  // state, capture and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FIND;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;

      case (state_r)
        S_FIND: begin
          if (accept) begin
            state_r <= S_PLACE;
          end
        end
        S_PLACE: begin
          if (out_free) begin
            state_r <= S_FIND;
          end
        end
        default: begin
          state_r <= S_FIND;
        end
      endcase

      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    // payload captures, no reset
    if (accept) begin
      act_r     <= in_action;
      id_r      <= key_id;
      cr_r      <= in_cr_sat;
      full_r    <= (count_r == CNT_FULL);
      found_r   <= found;
      hit_ent_r <= hit_ent;
      hit_pos_r <= hit_pos;
    end

    if (finish) begin
      out_status_r     <= res_status;
      out_found_id_r   <= ID_FIELD_W'(res_id);
      out_found_cc_r   <= res_cc;
      out_found_rc_r   <= res_rc;
      out_found_pos_r  <= POS_FIELD_W'(res_pos);
      out_total_r      <= TOTAL_W'(count_nxt);
      out_head_valid_r <= (count_nxt != '0);
      out_head_id_r    <= (count_nxt != '0) ? ID_FIELD_W'(head_ent[EW-1 -: ID_W]) : '0;
      out_head_cr_r    <= (count_nxt != '0) ? head_ent[CRED_W-1:0] : '0;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_status              = out_status_r;
  assign out_found_id            = out_found_id_r;
  assign out_found_create_credit = out_found_cc_r;
  assign out_found_real_credit   = out_found_rc_r;
  assign out_found_position      = out_found_pos_r;
  assign out_entry_total         = out_total_r;
  assign out_head_valid          = out_head_valid_r;
  assign out_head_id             = out_head_id_r;
  assign out_head_credit         = out_head_cr_r;

`ifndef ASSERT_OFF
  // the entry count never passes the queue depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above queue depth");

  // a placement only happens with a free slot and loads exactly one cell
  a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.place |-> (count_r < CNT_FULL) && $onehot(load_vec))
    else $error("placement without a single free slot");

  // at most one cell reports the first id match
  a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one first match in the chain");

  // an accepted item is always followed by the placement cycle
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_PLACE))
    else $error("accepted item did not move to placement");

  // a result appears only when the placement cycle completes
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(finish))
    else $error("result without a completed item");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the credit ordered ready queue
// Drives insert, remove, re-credit and look-up transfers with random gaps and
// output stalls, predicts every result from a software copy of the sorted
// queue, and compares each result field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

import coq_pkg::*;

localparam int unsigned TB_DEPTH      = 16;
localparam int unsigned TB_ID_BITS    = 8;
localparam int unsigned TB_MAX_CREDIT = 100;

// one result of the queue, as seen on the out_ ports
typedef struct packed {
  logic [STATUS_W-1:0]    status;
  logic [ID_FIELD_W-1:0]  found_id;
  logic [CRED_W-1:0]      found_cc;
  logic [CRED_W-1:0]      found_rc;
  logic [POS_FIELD_W-1:0] found_pos;
  logic [TOTAL_W-1:0]     total;
  logic                   head_valid;
  logic [ID_FIELD_W-1:0]  head_id;
  logic [CRED_W-1:0]      head_credit;
} queue_result_t;

// software copy of the sorted queue plus the list of results still owed
class ready_queue_scoreboard;
  logic [ID_FIELD_W-1:0] slot_tid [TB_DEPTH];
  logic [CRED_W-1:0]     slot_cc  [TB_DEPTH];
  logic [CRED_W-1:0]     slot_rc  [TB_DEPTH];
  int                    fill;
  queue_result_t         owed_q[$];
  int                    errors;
  int                    checked;
  int                    act_seen [4];
  int                    st_seen  [3];
  int                    peak_fill;

  function new();
    fill      = 0;
    errors    = 0;
    checked   = 0;
    peak_fill = 0;
    foreach (act_seen[i]) act_seen[i] = 0;
    foreach (st_seen[i]) st_seen[i] = 0;
  endfunction

  function int pending();
    return owed_q.size();
  endfunction

  // first slot from the head holding this id, fill when absent
  function int slot_of_id(logic [ID_FIELD_W-1:0] tid);
    for (int i = 0; i < fill; i++)
      if (slot_tid[i] == tid) return i;
    return fill;
  endfunction

  // behind every entry with credit greater or equal
  function int sorted_slot(logic [CRED_W-1:0] rc);
    int i;
    i = 0;
    while (i < fill && slot_rc[i] >= rc) i++;
    return i;
  endfunction

  function void open_gap(int p, logic [ID_FIELD_W-1:0] tid, logic [CRED_W-1:0] cc,
                         logic [CRED_W-1:0] rc);
    for (int i = fill; i > p; i--) begin
      slot_tid[i] = slot_tid[i-1];
      slot_cc[i]  = slot_cc[i-1];
      slot_rc[i]  = slot_rc[i-1];
    end
    slot_tid[p] = tid;
    slot_cc[p]  = cc;
    slot_rc[p]  = rc;
    fill++;
    if (fill > peak_fill) peak_fill = fill;
  endfunction

  function void close_gap(int p);
    for (int i = p; i + 1 < fill; i++) begin
      slot_tid[i] = slot_tid[i+1];
      slot_cc[i]  = slot_cc[i+1];
      slot_rc[i]  = slot_rc[i+1];
    end
    fill--;
  endfunction

  // accepted input transfer: update the copy and queue the result it owes
  function void note_input(logic [ACT_W-1:0] act, logic [ID_FIELD_W-1:0] raw_id,
                           logic [CRED_W-1:0] raw_credit);
    queue_result_t         r;
    logic [ID_FIELD_W-1:0] tid;
    logic [CRED_W-1:0]     cr;
    logic [CRED_W-1:0]     kept_cc;
    int                    p;
    r   = '0;
    tid = raw_id & ID_FIELD_W'((1 << TB_ID_BITS) - 1);
    cr  = (raw_credit > CRED_W'(TB_MAX_CREDIT)) ? CRED_W'(TB_MAX_CREDIT) : raw_credit;
    act_seen[act]++;
    if (act == ACT_INSERT) begin
      if (fill >= TB_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        p = sorted_slot(cr);
        open_gap(p, tid, cr, cr);
        r.found_id  = tid;
        r.found_cc  = cr;
        r.found_rc  = cr;
        r.found_pos = POS_FIELD_W'(p);
      end
    end else begin
      p = slot_of_id(tid);
      if (p >= fill) begin
        r.status = ST_NOTFOUND;
      end else if (act == ACT_REMOVE) begin
        r.found_id  = slot_tid[p];
        r.found_cc  = slot_cc[p];
        r.found_rc  = slot_rc[p];
        r.found_pos = POS_FIELD_W'(p);
        close_gap(p);
      end else if (act == ACT_CHANGE) begin
        kept_cc = slot_cc[p];
        close_gap(p);
        p = sorted_slot(cr);
        open_gap(p, tid, kept_cc, cr);
        r.found_id  = tid;
        r.found_cc  = kept_cc;
        r.found_rc  = cr;
        r.found_pos = POS_FIELD_W'(p);
      end else begin
        r.found_id  = slot_tid[p];
        r.found_cc  = slot_cc[p];
        r.found_rc  = slot_rc[p];
        r.found_pos = POS_FIELD_W'(p);
      end
    end
    r.total = TOTAL_W'(fill);
    if (fill > 0) begin
      r.head_valid  = 1'b1;
      r.head_id     = slot_tid[0];
      r.head_credit = slot_rc[0];
    end
    st_seen[r.status]++;
    owed_q.push_back(r);
  endfunction

  function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // accepted result transfer: compare against the oldest owed result
  function void check_result(queue_result_t got);
    queue_result_t want;
    if (owed_q.size() == 0) begin
      $display("%0t result with nothing owed: status %0d id %0d", $time, got.status,
               got.found_id);
      errors++;
      return;
    end
    want = owed_q.pop_front();
    checked++;
    compare_field("status", want.status, got.status);
    compare_field("found_id", want.found_id, got.found_id);
    compare_field("found_create_credit", want.found_cc, got.found_cc);
    compare_field("found_real_credit", want.found_rc, got.found_rc);
    compare_field("found_position", want.found_pos, got.found_pos);
    compare_field("entry_total", want.total, got.total);
    compare_field("head_valid", want.head_valid, got.head_valid);
    compare_field("head_id", want.head_id, got.head_id);
    compare_field("head_credit", want.head_credit, got.head_credit);
  endfunction
endclass

module tb;

  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_TAIL   = 150;   // last random items run with no gaps or stalls

  logic                   clk;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic [ACT_W-1:0]       in_action    = ACT_LOOKUP;
  logic [ID_FIELD_W-1:0]  in_thread_id = '0;
  logic [CRED_W-1:0]      in_credit    = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [STATUS_W-1:0]    out_status;
  logic [ID_FIELD_W-1:0]  out_found_id;
  logic [CRED_W-1:0]      out_found_create_credit;
  logic [CRED_W-1:0]      out_found_real_credit;
  logic [POS_FIELD_W-1:0] out_found_position;
  logic [TOTAL_W-1:0]     out_entry_total;
  logic                   out_head_valid;
  logic [ID_FIELD_W-1:0]  out_head_id;
  logic [CRED_W-1:0]      out_head_credit;

  // set for the tail of the run: both sides stop idling
  logic                   quiet_phase  = 1'b0;

  ready_queue_scoreboard  sb;

  credit_ordered_ready_queue_unit #(
    .QUEUE_DEPTH (TB_DEPTH),
    .ID_BITS     (TB_ID_BITS),
    .MAX_CREDIT  (TB_MAX_CREDIT)
  ) DUT (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_action               (in_action),
    .in_thread_id            (in_thread_id),
    .in_credit               (in_credit),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_status              (out_status),
    .out_found_id            (out_found_id),
    .out_found_create_credit (out_found_create_credit),
    .out_found_real_credit   (out_found_real_credit),
    .out_found_position      (out_found_position),
    .out_entry_total         (out_entry_total),
    .out_head_valid          (out_head_valid),
    .out_head_id             (out_head_id),
    .out_head_credit         (out_head_credit)
  );

  // 2 time unit clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #1000000;
    $display("timeout with %0d results still owed", sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  // result monitor: values read here are the ones before the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_status, out_found_id, out_found_create_credit,
                        out_found_real_credit, out_found_position, out_entry_total,
                        out_head_valid, out_head_id, out_head_credit});
    end
  end

  // receiver back-pressure: random stall bursts outside the quiet phase
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!quiet_phase && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // present one item and hold it until the transfer happens
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [ID_FIELD_W-1:0] tid,
                           input logic [CRED_W-1:0] cr);
    in_action    <= act;
    in_thread_id <= tid;
    in_credit    <= cr;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(act, tid, cr);
  endtask

  // sender gap: in_valid held low for a random stretch
  task automatic sender_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 18)) @(posedge clk);
  endtask

  // mostly ids that are live in the queue, so remove and change find something
  function automatic logic [ID_FIELD_W-1:0] pick_id();
    if (sb.fill > 0 && $urandom_range(0, 3) != 0)
      return sb.slot_tid[$urandom_range(0, sb.fill - 1)];
    return ID_FIELD_W'($urandom_range(0, 255));
  endfunction

  // in range mostly, some above the ceiling, some repeats to test equal-credit order
  function automatic logic [CRED_W-1:0] pick_credit();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 2) return CRED_W'($urandom_range(TB_MAX_CREDIT + 1, CRED_FIELD_MAX));
    if (roll == 2) return CRED_W'(0);
    if (roll == 3) return CRED_W'(TB_MAX_CREDIT);
    if (roll < 6) return CRED_W'(50);
    return CRED_W'($urandom_range(0, TB_MAX_CREDIT));
  endfunction

  // action mix follows a mood: 0 fills the queue, 1 drains it, 2 is even
  function automatic logic [ACT_W-1:0] pick_action(int mood);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    case (mood)
      0: begin
        if (roll < 55) return ACT_INSERT;
        if (roll < 70) return ACT_REMOVE;
        if (roll < 85) return ACT_CHANGE;
        return ACT_LOOKUP;
      end
      1: begin
        if (roll < 15) return ACT_INSERT;
        if (roll < 65) return ACT_REMOVE;
        if (roll < 85) return ACT_CHANGE;
        return ACT_LOOKUP;
      end
      default: begin
        if (roll < 25) return ACT_INSERT;
        if (roll < 50) return ACT_REMOVE;
        if (roll < 75) return ACT_CHANGE;
        return ACT_LOOKUP;
      end
    endcase
  endfunction

  task automatic run_random(input int n_items);
    int mood;
    int mood_left;
    mood      = 0;
    mood_left = 0;
    for (int k = 0; k < n_items; k++) begin
      if (mood_left == 0) begin
        mood      = $urandom_range(0, 2);
        mood_left = $urandom_range(40, 80);
      end
      mood_left--;
      if (k == n_items - QUIET_TAIL) quiet_phase <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 7) == 0) sender_gap();
      send_item(pick_action(mood), pick_id(), pick_credit());
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue: every id lookup fails
    send_item(ACT_LOOKUP, 8'd5, 7'd0);
    send_item(ACT_REMOVE, 8'd5, 7'd0);
    send_item(ACT_CHANGE, 8'd5, 7'd60);
    // credit above the ceiling saturates, then the extremes of id and credit
    send_item(ACT_INSERT, 8'hFF, 7'h7F);
    send_item(ACT_INSERT, 8'h00, 7'd0);
    // equal credit goes behind the saturated one
    send_item(ACT_INSERT, 8'd7, 7'd100);
    // duplicate id: lookup must pick the one nearest the head
    send_item(ACT_INSERT, 8'd7, 7'd50);
    send_item(ACT_LOOKUP, 8'd7, 7'd0);
    // re-credit to zero lands behind the other zero
    send_item(ACT_CHANGE, 8'd7, 7'd0);
    // re-credit above the ceiling, keeps creation credit
    send_item(ACT_CHANGE, 8'hFF, 7'h7F);
    send_item(ACT_REMOVE, 8'h00, 7'd0);
    send_item(ACT_LOOKUP, 8'h00, 7'd0);
    // fill to the top, then one insert into a full queue
    for (int k = 0; k < 13; k++)
      send_item(ACT_INSERT, ID_FIELD_W'(8'h80 + k), CRED_W'(k * 9));
    send_item(ACT_INSERT, 8'hAA, 7'd1);

    run_random(RANDOM_ITEMS);
    in_valid <= 1'b0;

    // drain, then wait for any stray result
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d transfers: insert %0d, remove %0d, change %0d, lookup %0d",
             sb.checked, sb.act_seen[ACT_INSERT], sb.act_seen[ACT_REMOVE],
             sb.act_seen[ACT_CHANGE], sb.act_seen[ACT_LOOKUP]);
    $display("outcomes: ok %0d, id not found %0d, queue full %0d, deepest fill %0d",
             sb.st_seen[ST_OK], sb.st_seen[ST_NOTFOUND], sb.st_seen[ST_FULL],
             sb.peak_fill);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
design/coq_pkg.sv
design/coq_cell.sv
design/credit_ordered_ready_queue_unit.sv
tb/tb.sv
